[sv/ffba_pkg.sv]
package ffba_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int SIZE_W     = 16;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 6;

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 40;
	localparam int S_PAD_W    = S_TDATA_W - IDX_W - 2 * SIZE_W;
	localparam int M_PAD_W    = M_TDATA_W - IDX_W - 2 * SIZE_W;

	// command queue between front and back
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = 1;
	localparam int Q_CNT_W    = 2;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_PICK = 1'b1
	} back_state_t;

	// one classified item: load carries the block size, allocate the request
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [SIZE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_status_t;

endpackage

[sv/first_fit_block_allocator.sv]
// First-fit block allocator. Load items (tuser 0) write one block's size and free it; allocate
// items (tuser 1) take the lowest-numbered free block below block_count whose size covers the
// request and return its index, size and leftover, or found = 0 with zero fields. Items enter a
// two-entry command queue and are accepted every cycle while it has room. The back end takes a
// load at once; an allocate is a parallel compare of all 32 blocks, then a priority pick that
// updates the used marks, waits on a held output register and blocks new items, so sustained
// throughput is one load per cycle outside a pick. Used marks and block_count clear at reset;
// block sizes do not, so load every block below block_count before allocating. The user
// writes block_count via the always-ready cfg port only while the block is idle, unenforced.
module first_fit_block_allocator
	import ffba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data,      // block_count
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,       // block_index, block_size, request_size
	input  logic                  s_tuser,       // opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,       // chosen_block, chosen_size, fragment
	output logic                  m_tuser        // found
);

	cmd_t          cmd;
	queue_status_t q_status;
	logic          cmd_pop;

	assign cfg_ready = 1'b1;

	ffba_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.q_status (q_status)
	);

	ffba_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.q_status (q_status),
		.cmd_pop  (cmd_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> q_status.valid)
		else $error("command popped from empty queue");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_status.valid)
		else $error("input stalled with empty queue");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("not-found result carries nonzero fields");

	a_frag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(m_tdata[IDX_W + SIZE_W +: SIZE_W] <= m_tdata[IDX_W +: SIZE_W]))
		else $error("fragment larger than chosen block");

endmodule

[sv/ffba_front.sv]
module ffba_front
	import ffba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  cmd_pop,
	output cmd_t                  cmd,
	output queue_status_t         q_status
);

	cmd_t               q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	cmd_t               in_cmd;
	logic               push;

	// classify: keep only the size field that the operation needs
	always_comb begin
		in_cmd.op  = op_t'(s_tuser);
		in_cmd.idx = s_tdata[IDX_W-1:0];
		if (in_cmd.op == OP_LOAD) begin
			in_cmd.value = s_tdata[IDX_W +: SIZE_W];
		end else begin
			in_cmd.value = s_tdata[IDX_W + SIZE_W +: SIZE_W];
		end
	end

	assign q_status.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_status.valid = (count_q != '0);
	assign s_tready       = !q_status.full;
	assign push           = s_tvalid && s_tready;
	assign cmd            = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/ffba_back.sv]
module ffba_back
	import ffba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CNT_W-1:0]      cfg_data,
	input  cmd_t                  cmd,
	input  queue_status_t         q_status,
	output logic                  cmd_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tuser
);

	logic [SIZE_W-1:0]     size_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] used_q;
	logic [CNT_W-1:0]      block_count_q;
	back_state_t           state_q;
	back_state_t           state_d;

	logic [NUM_BLOCKS-1:0] fit;
	logic [NUM_BLOCKS-1:0] fit_s1;
	logic [SIZE_W-1:0]     req_s1;

	logic                  hit;
	logic [IDX_W-1:0]      pick_idx;
	logic [SIZE_W-1:0]     pick_size;
	logic [SIZE_W-1:0]     pick_frag;
	logic                  out_load;

	logic                  out_valid_q;
	logic                  found_q;
	logic [IDX_W-1:0]      block_q;
	logic [SIZE_W-1:0]     chosen_size_q;
	logic [SIZE_W-1:0]     fragment_q;

	// compare every searched block against the request at the queue head
	always_comb begin
		for (int j = 0; j < NUM_BLOCKS; j++) begin
			fit[j] = !used_q[j] && (size_q[j] >= cmd.value)
				&& (CNT_W'(j) < block_count_q);
		end
	end

	// lowest-numbered fitting block wins
	always_comb begin
		hit      = 1'b0;
		pick_idx = '0;
		for (int j = 0; j < NUM_BLOCKS; j++) begin
			if (fit_s1[j] && !hit) begin
				hit      = 1'b1;
				pick_idx = IDX_W'(j);
			end
		end
		pick_size = hit ? size_q[pick_idx] : '0;
		pick_frag = hit ? (pick_size - req_s1) : '0;
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_status.valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_ALLOC) begin
						state_d = ST_PICK;
					end
				end
			end
			ST_PICK: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_LOAD) begin
			size_q[cmd.idx] <= cmd.value;
		end
		if (cmd_pop && cmd.op == OP_ALLOC) begin
			fit_s1 <= fit;
			req_s1 <= cmd.value;
		end
		if (out_load) begin
			found_q       <= hit;
			block_q       <= pick_idx;
			chosen_size_q <= pick_size;
			fragment_q    <= pick_frag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			block_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				block_count_q <= cfg_data;
			end
			if (cmd_pop && cmd.op == OP_LOAD) begin
				used_q[cmd.idx] <= 1'b0;
			end
			if (out_load && hit) begin
				used_q[pick_idx] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, fragment_q, chosen_size_q, block_q};

endmodule
